// File: src/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the domain name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int unsigned CNT_W  = 6;
  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

  // flush command passed from the front to the back
  typedef struct packed {
    logic             end_flag;
    logic             trunc;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_LEN  = 5'b00010,
    B_RD   = 5'b00100,
    B_CHR  = 5'b01000,
    B_TERM = 5'b10000
  } back_state_e;

endpackage

// File: src/dnle_ram.sv
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dnle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/dnle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dnle_cmd_fifo
// Two-entry queue of flush commands between the front and the back.
// ----------------------------------------------------------------------------
module dnle_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dnle_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output dnle_pkg::cmd_t pop_data_o,
  output logic           empty_o
);

  dnle_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           do_push, do_pop;

  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name items, stores label characters and queues flush commands.
// ----------------------------------------------------------------------------
module dnle_front #(
  parameter int unsigned LABEL_DEPTH = 32,
  localparam int unsigned AW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dnle_pkg::BYTE_W-1:0]  name_char_i,
  input  logic                         end_of_name_i,
  input  logic                         fifo_full_i,
  input  logic                         fifo_empty_i,
  input  logic                         back_busy_i,
  output logic                         push_o,
  output dnle_pkg::cmd_t               push_data_o,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic [dnle_pkg::BYTE_W-1:0]  wdata_o
);

  localparam logic [dnle_pkg::CNT_W-1:0] DEPTH_CNT = dnle_pkg::CNT_W'(LABEL_DEPTH);

  logic [dnle_pkg::CNT_W-1:0] count_q, count_d;
  logic                       ovf_q, ovf_d;
  logic                       is_sep, accept, has_room;

  assign is_sep   = end_of_name_i || (name_char_i == dnle_pkg::DOT_CHAR);
  // characters wait until the back has read out the previous label
  assign in_ready_o = is_sep ? !fifo_full_i : (fifo_empty_i && !back_busy_i);
  assign accept   = in_valid_i && in_ready_o;
  assign has_room = (count_q < DEPTH_CNT);

  assign push_o               = accept && is_sep;
  assign push_data_o.end_flag = end_of_name_i;
  assign push_data_o.trunc    = ovf_q;
  assign push_data_o.count    = count_q;

  assign we_o    = accept && !is_sep && has_room;
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = name_char_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (is_sep) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (has_room) begin
        count_d = count_q + dnle_pkg::CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: src/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Carries out flush commands: length byte, label characters, terminator.
// ----------------------------------------------------------------------------
module dnle_back #(
  parameter int unsigned LABEL_DEPTH = 32,
  localparam int unsigned AW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fifo_empty_i,
  input  dnle_pkg::cmd_t               cmd_i,
  output logic                         pop_o,
  output logic                         busy_o,
  output logic                         re_o,
  output logic [AW-1:0]                raddr_o,
  input  logic [dnle_pkg::BYTE_W-1:0]  rdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dnle_pkg::BYTE_W-1:0]  wire_byte_o,
  output logic                         truncated_o,
  output logic                         last_of_run_o
);

  dnle_pkg::back_state_e      state_q, state_d;
  dnle_pkg::cmd_t             cur_q, cur_d;
  logic [dnle_pkg::CNT_W-1:0] idx_q, idx_d;
  logic                       oval_q, oval_d;
  logic [dnle_pkg::BYTE_W-1:0] obyte_q, obyte_d;
  logic                       otrunc_q, otrunc_d;
  logic                       olast_q, olast_d;
  logic                       slot_free, last_chr;

  assign slot_free = !oval_q || out_ready_i;
  assign last_chr  = ((idx_q + dnle_pkg::CNT_W'(1)) == cur_q.count);

  assign busy_o        = (state_q != dnle_pkg::B_IDLE);
  assign pop_o         = (state_q == dnle_pkg::B_IDLE) && !fifo_empty_i;
  assign re_o          = (state_q == dnle_pkg::B_RD);
  assign raddr_o       = idx_q[AW-1:0];
  assign out_valid_o   = oval_q;
  assign wire_byte_o   = obyte_q;
  assign truncated_o   = otrunc_q;
  assign last_of_run_o = olast_q;

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    idx_d    = idx_q;
    oval_d   = oval_q && !out_ready_i;
    obyte_d  = obyte_q;
    otrunc_d = otrunc_q;
    olast_d  = olast_q;
    case (state_q)
      dnle_pkg::B_IDLE: begin
        if (!fifo_empty_i) begin
          cur_d   = cmd_i;
          idx_d   = '0;
          state_d = dnle_pkg::B_LEN;
        end
      end
      dnle_pkg::B_LEN: begin
        if (slot_free) begin
          oval_d   = 1'b1;
          obyte_d  = dnle_pkg::BYTE_W'(cur_q.count);
          otrunc_d = cur_q.trunc;
          olast_d  = (cur_q.count == '0) && !cur_q.end_flag;
          if (cur_q.count != '0) begin
            state_d = dnle_pkg::B_RD;
          end else if (cur_q.end_flag) begin
            state_d = dnle_pkg::B_TERM;
          end else begin
            state_d = dnle_pkg::B_IDLE;
          end
        end
      end
      dnle_pkg::B_RD: begin
        state_d = dnle_pkg::B_CHR;
      end
      dnle_pkg::B_CHR: begin
        if (slot_free) begin
          oval_d   = 1'b1;
          obyte_d  = rdata_i;
          otrunc_d = cur_q.trunc;
          olast_d  = last_chr && !cur_q.end_flag;
          idx_d    = idx_q + dnle_pkg::CNT_W'(1);
          if (!last_chr) begin
            state_d = dnle_pkg::B_RD;
          end else if (cur_q.end_flag) begin
            state_d = dnle_pkg::B_TERM;
          end else begin
            state_d = dnle_pkg::B_IDLE;
          end
        end
      end
      dnle_pkg::B_TERM: begin
        if (slot_free) begin
          oval_d   = 1'b1;
          obyte_d  = dnle_pkg::TERM_BYTE;
          otrunc_d = 1'b0;
          olast_d  = 1'b1;
          state_d  = dnle_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = dnle_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dnle_pkg::B_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    obyte_q  <= obyte_d;
    otrunc_q <= otrunc_d;
    olast_q  <= olast_d;
  end

endmodule

// File: src/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Turns a dotted domain name into length-prefixed wire-format labels.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one name character per item, or an
// end_of_name item that closes the name. Output channel (out_valid_o/
// out_ready_i): one wire byte per item, with the label's truncated flag and
// last_of_run marking the final byte caused by one input item.
// An ordinary character is written to the label RAM, or dropped and flagged as
// truncated when the label is full. A dot or end item is queued as a flush
// command (two-entry queue); the back then sends the length byte, reads each
// character from the RAM and loads it into the output register, and adds the
// terminator after an end item. A separator's command passes the queue and
// the back's command register before its length byte is loaded. Characters of
// the next label are held off until the back has read out the current label.
// When the receiver stalls, the output register holds its byte and the back
// waits; the front keeps queuing separators until the queue is full.
// Reset empties the label, the queue and the output register.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
  parameter int unsigned LABEL_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dnle_pkg::BYTE_W-1:0] name_char_i,
  input  logic                        end_of_name_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dnle_pkg::BYTE_W-1:0] wire_byte_o,
  output logic                        truncated_o,
  output logic                        last_of_run_o
);

  localparam int unsigned AW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;

  logic                        fifo_full, fifo_empty, back_busy;
  logic                        push, pop;
  dnle_pkg::cmd_t              push_data, pop_data;
  logic                        we, re;
  logic [AW-1:0]               waddr, raddr;
  logic [dnle_pkg::BYTE_W-1:0] wdata, rdata;

  dnle_front #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .name_char_i   (name_char_i),
    .end_of_name_i (end_of_name_i),
    .fifo_full_i   (fifo_full),
    .fifo_empty_i  (fifo_empty),
    .back_busy_i   (back_busy),
    .push_o        (push),
    .push_data_o   (push_data),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata)
  );

  dnle_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (fifo_empty)
  );

  dnle_ram #(
    .WIDTH (dnle_pkg::BYTE_W),
    .DEPTH (LABEL_DEPTH)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dnle_back #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .cmd_i         (pop_data),
    .pop_o         (pop),
    .busy_o        (back_busy),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .wire_byte_o   (wire_byte_o),
    .truncated_o   (truncated_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
